// ----- hdl/hpci_pkg.sv -----
package hpci_pkg;

   localparam int CNT_W   = 8;
   localparam int INDEX_W = 22;
   localparam int ADDR_W  = 3;
   localparam int DATA_W  = 32;

   // Inverse of 3 modulo 2**INDEX_W: exact division by 3 of a multiple of 3
   localparam logic [INDEX_W-1:0] INV3 = INDEX_W'(((2 ** (INDEX_W + 1)) + 1) / 3);

   // Register indexes, taken from paddr word bits
   localparam logic REG_SAMPLE_TOTAL = 1'b0;

   // Case codes for the allele relabel, {flip left, flip right}
   localparam logic [1:0] FLIP_NONE  = 2'b00;
   localparam logic [1:0] FLIP_RIGHT = 2'b01;
   localparam logic [1:0] FLIP_LEFT  = 2'b10;
   localparam logic [1:0] FLIP_BOTH  = 2'b11;

   typedef struct packed {
      logic [CNT_W-1:0] count_00;
      logic [CNT_W-1:0] count_10;
      logic [CNT_W-1:0] count_01;
      logic [CNT_W-1:0] count_11;
      logic [CNT_W-1:0] count_0m;
      logic [CNT_W-1:0] count_1m;
      logic [CNT_W-1:0] count_m0;
      logic [CNT_W-1:0] count_m1;
      logic [CNT_W-1:0] count_mm;
   } req_type;

   typedef struct packed {
      logic [CNT_W-1:0]   canon_00;
      logic [CNT_W-1:0]   canon_10;
      logic [CNT_W-1:0]   canon_01;
      logic [CNT_W-1:0]   canon_11;
      logic [CNT_W-1:0]   canon_0m;
      logic [CNT_W-1:0]   canon_1m;
      logic [CNT_W-1:0]   canon_m0;
      logic [CNT_W-1:0]   canon_m1;
      logic [CNT_W-1:0]   canon_mm;
      logic [INDEX_W-1:0] pair_index;
   } rsp_type;

   // One pipeline beat: counts with their valid bit
   typedef struct packed {
      logic    valid;
      req_type counts;
   } beat_type;

endpackage

// ----- hdl/hpci_csr.sv -----
module hpci_csr
   import hpci_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output logic [CNT_W-1:0]  sample_total
);

   logic [CNT_W-1:0] sample_total_ff;
   logic [CNT_W-1:0] sample_total_in;
   logic             wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   // Write sample_total on an access beat; other registers ignore writes
   always_comb begin
      sample_total_in = sample_total_ff;
      if (wr_en && (paddr[ADDR_W-1] == REG_SAMPLE_TOTAL)) begin
         sample_total_in = pwdata[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_total_ff <= '0;
      end else begin
         sample_total_ff <= sample_total_in;
      end
   end

   // Read back
   always_comb begin
      prdata = '0;
      if (paddr[ADDR_W-1] == REG_SAMPLE_TOTAL) begin
         prdata = {{(DATA_W-CNT_W){1'b0}}, sample_total_ff};
      end
   end

   assign sample_total = sample_total_ff;

endmodule

// ----- hdl/hpci_relabel.sv -----
module hpci_relabel
   import hpci_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  req_type          in_counts,
   input  logic [CNT_W-1:0] sample_total,
   output beat_type         out_beat
);

   logic     cap_valid_ff;
   req_type  cap_counts_ff;
   logic     lab_valid_ff;
   req_type  lab_counts_ff;
   req_type  lab_counts_in;
   logic     exc_valid_ff;
   req_type  exc_counts_ff;
   req_type  exc_counts_in;

   logic [CNT_W+1:0] left_sum;
   logic [CNT_W+1:0] right_sum;
   logic [1:0]       flip;
   logic [CNT_W:0]   left_minor;
   logic [CNT_W:0]   right_minor;

   // Stage 1: capture the request beat
   always_ff @(posedge clock) begin
      cap_counts_ff <= in_counts;
      if (reset) begin
         cap_valid_ff <= 1'b0;
      end else begin
         cap_valid_ff <= in_valid;
      end
   end

   // Stage 2: swap allele labels at each site where allele 1 is the majority
   assign left_sum  = {2'b00, cap_counts_ff.count_10} + {2'b00, cap_counts_ff.count_11}
                    + {2'b00, cap_counts_ff.count_1m};
   assign right_sum = {2'b00, cap_counts_ff.count_01} + {2'b00, cap_counts_ff.count_11}
                    + {2'b00, cap_counts_ff.count_m1};
   assign flip[1] = {left_sum, 1'b0} > {3'b000, sample_total};
   assign flip[0] = {right_sum, 1'b0} > {3'b000, sample_total};

   always_comb begin
      lab_counts_in = cap_counts_ff;
      case (flip)
         FLIP_BOTH: begin
            lab_counts_in.count_00 = cap_counts_ff.count_11;
            lab_counts_in.count_11 = cap_counts_ff.count_00;
            lab_counts_in.count_10 = cap_counts_ff.count_01;
            lab_counts_in.count_01 = cap_counts_ff.count_10;
            lab_counts_in.count_0m = cap_counts_ff.count_1m;
            lab_counts_in.count_1m = cap_counts_ff.count_0m;
            lab_counts_in.count_m0 = cap_counts_ff.count_m1;
            lab_counts_in.count_m1 = cap_counts_ff.count_m0;
         end
         FLIP_LEFT: begin
            lab_counts_in.count_00 = cap_counts_ff.count_10;
            lab_counts_in.count_10 = cap_counts_ff.count_00;
            lab_counts_in.count_01 = cap_counts_ff.count_11;
            lab_counts_in.count_11 = cap_counts_ff.count_01;
            lab_counts_in.count_0m = cap_counts_ff.count_1m;
            lab_counts_in.count_1m = cap_counts_ff.count_0m;
         end
         FLIP_RIGHT: begin
            lab_counts_in.count_00 = cap_counts_ff.count_01;
            lab_counts_in.count_01 = cap_counts_ff.count_00;
            lab_counts_in.count_10 = cap_counts_ff.count_11;
            lab_counts_in.count_11 = cap_counts_ff.count_10;
            lab_counts_in.count_m0 = cap_counts_ff.count_m1;
            lab_counts_in.count_m1 = cap_counts_ff.count_m0;
         end
         default: begin
            lab_counts_in = cap_counts_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      lab_counts_ff <= lab_counts_in;
      if (reset) begin
         lab_valid_ff <= 1'b0;
      end else begin
         lab_valid_ff <= cap_valid_ff;
      end
   end

   // Stage 3: exchange the sites when the right minor total is larger
   assign left_minor  = {1'b0, lab_counts_ff.count_10} + {1'b0, lab_counts_ff.count_1m};
   assign right_minor = {1'b0, lab_counts_ff.count_01} + {1'b0, lab_counts_ff.count_m1};

   always_comb begin
      exc_counts_in = lab_counts_ff;
      if (right_minor > left_minor) begin
         exc_counts_in.count_10 = lab_counts_ff.count_01;
         exc_counts_in.count_01 = lab_counts_ff.count_10;
         exc_counts_in.count_1m = lab_counts_ff.count_m1;
         exc_counts_in.count_m1 = lab_counts_ff.count_1m;
         exc_counts_in.count_0m = lab_counts_ff.count_m0;
         exc_counts_in.count_m0 = lab_counts_ff.count_0m;
      end
   end

   always_ff @(posedge clock) begin
      exc_counts_ff <= exc_counts_in;
      if (reset) begin
         exc_valid_ff <= 1'b0;
      end else begin
         exc_valid_ff <= lab_valid_ff;
      end
   end

   assign out_beat.valid  = exc_valid_ff;
   assign out_beat.counts = exc_counts_ff;

endmodule

// ----- hdl/hpci_index.sv -----
module hpci_index
   import hpci_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  beat_type in_beat,
   output logic     out_valid,
   output rsp_type  out_rsp
);

   localparam int P_W   = CNT_W + 1;          // p1, p2
   localparam int TRI_W = 2 * P_W - 1;        // p1(p1-1)/2
   localparam int FAC_W = P_W + 1;            // p1+4
   localparam int SQ_W  = 2 * P_W;            // p2(p2+1)/2

   logic [P_W-1:0]       p1;
   logic [P_W-1:0]       p2;
   logic [2*P_W-1:0]     p1_prod;
   logic [P_W+FAC_W-1:0] p2_prod;

   logic                 s1_valid_ff;
   req_type              s1_counts_ff;
   logic [TRI_W-1:0]     s1_tri_ff;
   logic [FAC_W-1:0]     s1_fac_ff;
   logic [SQ_W-1:0]      s1_sq_ff;

   logic [TRI_W+FAC_W-1:0] cube_prod;
   logic                 s2_valid_ff;
   req_type              s2_counts_ff;
   logic [INDEX_W-1:0]   s2_cube_ff;
   logic [SQ_W-1:0]      s2_sq_ff;

   logic [2*INDEX_W-1:0] third_prod;
   logic                 s3_valid_ff;
   req_type              s3_counts_ff;
   logic [INDEX_W-1:0]   s3_third_ff;
   logic [SQ_W-1:0]      s3_sq_ff;

   logic [INDEX_W-1:0]   index_in;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;
   rsp_type              rsp_in;

   // Stage 1: allele totals and the two quadratic terms
   assign p1 = {1'b0, in_beat.counts.count_10} + {1'b0, in_beat.counts.count_11};
   assign p2 = {1'b0, in_beat.counts.count_01} + {1'b0, in_beat.counts.count_11};
   assign p1_prod = p1 * (p1 - P_W'(1));
   assign p2_prod = p2 * ({1'b0, p2} + FAC_W'(1));

   always_ff @(posedge clock) begin
      s1_counts_ff <= in_beat.counts;
      s1_tri_ff    <= p1_prod[2*P_W-1:1];
      s1_fac_ff    <= {1'b0, p1} + FAC_W'(4);
      s1_sq_ff     <= p2_prod[SQ_W:1];
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_beat.valid;
      end
   end

   // Stage 2: cubic numerator, kept modulo the index width
   assign cube_prod = s1_tri_ff * s1_fac_ff;

   always_ff @(posedge clock) begin
      s2_counts_ff <= s1_counts_ff;
      s2_cube_ff   <= cube_prod[INDEX_W-1:0];
      s2_sq_ff     <= s1_sq_ff;
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // Stage 3: divide the exact multiple of 3 by multiplying it with the modular inverse of 3
   assign third_prod = s2_cube_ff * INV3;

   always_ff @(posedge clock) begin
      s3_counts_ff <= s2_counts_ff;
      s3_third_ff  <= third_prod[INDEX_W-1:0];
      s3_sq_ff     <= s2_sq_ff;
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // Stage 4: sum the terms and form the result beat
   assign index_in = s3_third_ff + INDEX_W'(s3_sq_ff)
                   + {{(INDEX_W-CNT_W){1'b0}}, s3_counts_ff.count_01};

   always_comb begin
      rsp_in.canon_00   = s3_counts_ff.count_00;
      rsp_in.canon_10   = s3_counts_ff.count_10;
      rsp_in.canon_01   = s3_counts_ff.count_01;
      rsp_in.canon_11   = s3_counts_ff.count_11;
      rsp_in.canon_0m   = s3_counts_ff.count_0m;
      rsp_in.canon_1m   = s3_counts_ff.count_1m;
      rsp_in.canon_m0   = s3_counts_ff.count_m0;
      rsp_in.canon_m1   = s3_counts_ff.count_m1;
      rsp_in.canon_mm   = s3_counts_ff.count_mm;
      rsp_in.pair_index = index_in;
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_rsp   = rsp_ff;

endmodule

// ----- hdl/haplotype_pair_canonicalize_index.sv -----
// Canonical form and table index of a two-site haplotype pair type. Pulse start
// with the nine counts on req_data; busy stays low, so a new beat is taken every
// cycle. Each beat comes out on rsp_data, marked by a one-cycle rsp_strobe, in order,
// after the three relabel stages and the four index stages; the receiver must take it
// then. The cubic term takes two chained multiplies. sample_total (byte address 0 of
// the APB port) sets the majority threshold and is to be written only while no beat
// is in flight.
module haplotype_pair_canonicalize_index
   import hpci_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  req_type           req_data,
   output logic              rsp_strobe,
   output rsp_type           rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   logic [CNT_W-1:0] sample_total;
   beat_type         canon_beat;
   logic             accept;

   // Every cycle is open for a new beat
   assign busy   = 1'b0;
   assign accept = start && !busy;

   hpci_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .sample_total (sample_total)
   );

   hpci_relabel u_relabel (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (accept),
      .in_counts    (req_data),
      .sample_total (sample_total),
      .out_beat     (canon_beat)
   );

   hpci_index u_index (
      .clock     (clock),
      .reset     (reset),
      .in_beat   (canon_beat),
      .out_valid (rsp_strobe),
      .out_rsp   (rsp_data)
   );

   // Every accepted beat leaves the pipeline as a result beat
   a_latency_fwd : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##7 rsp_strobe)
      else $error("accepted beat did not leave after seven cycles");

   // No result beat without a matching accepted beat
   a_latency_back : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, 7))
      else $error("result beat without a matching request");

   // Left site carries the larger or equal minor total after the exchange
   a_site_order : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ({1'b0, rsp_data.canon_10} + {1'b0, rsp_data.canon_1m}
                      >= {1'b0, rsp_data.canon_01} + {1'b0, rsp_data.canon_m1}))
      else $error("sites not in canonical order");

   // Monomorphic pairs map to index zero
   a_mono_index : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.canon_10 == '0 && rsp_data.canon_01 == '0
       && rsp_data.canon_11 == '0) |-> (rsp_data.pair_index == '0))
      else $error("monomorphic pair with nonzero index");

endmodule
